### rtl/cbor_pkg.sv
package cbor_pkg;

    // Request kinds on req_type
    localparam logic [2:0] REQ_INT    = 3'd0;
    localparam logic [2:0] REQ_ARRAY  = 3'd1;
    localparam logic [2:0] REQ_MAP    = 3'd2;
    localparam logic [2:0] REQ_BOOL   = 3'd3;
    localparam logic [2:0] REQ_TEXT   = 3'd4;
    localparam logic [2:0] REQ_BYTES  = 3'd5;
    localparam logic [2:0] REQ_DOUBLE = 3'd6;
    localparam logic [2:0] REQ_RSVD   = 3'd7;

    // Major type bits of the initial byte
    localparam logic [7:0] MT_UINT   = 8'h00;
    localparam logic [7:0] MT_NEGINT = 8'h20;
    localparam logic [7:0] MT_BYTES  = 8'h40;
    localparam logic [7:0] MT_TEXT   = 8'h60;
    localparam logic [7:0] MT_ARRAY  = 8'h80;
    localparam logic [7:0] MT_MAP    = 8'hA0;

    // Simple values
    localparam logic [7:0] SV_FALSE  = 8'hF4;
    localparam logic [7:0] SV_TRUE   = 8'hF5;
    localparam logic [7:0] SV_DOUBLE = 8'hFB;

    // Additional info codes for a following argument
    localparam logic [4:0] AI_ONE   = 5'd24;
    localparam logic [4:0] AI_TWO   = 5'd25;
    localparam logic [4:0] AI_FOUR  = 5'd26;
    localparam logic [4:0] AI_EIGHT = 5'd27;

    // Count of argument bytes after the initial byte (0..8)
    localparam int CNT_W = 4;

    // Load request from the classifier to the byte serializer
    typedef struct packed {
        logic              load;
        logic [7:0]        head;
        logic [CNT_W-1:0]  nfollow;
        logic [63:0]       args;    // first argument byte in [63:56]
    } cbor_load_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } cbor_state_t;

endpackage

### rtl/cbor_ser.sv
module cbor_ser
    import cbor_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cbor_load_t          ld,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                last_byte
);

    cbor_state_t       state_reg, state_next;
    logic [63:0]       shift_reg, shift_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              take;

    assign take = (state_reg == ST_EMIT) && out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ld.load)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready && (cnt_reg == '0))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Shared byte shifter: load head, then move one argument byte out per take
    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (state_reg == ST_IDLE && ld.load)
        begin
            shift_next = ld.args;
            cnt_next   = ld.nfollow;
            byte_next  = ld.head;
            last_next  = (ld.nfollow == '0);
        end
        else if (take && (cnt_reg != '0))
        begin
            byte_next  = shift_reg[63:56];
            shift_next = {shift_reg[55:0], 8'h00};
            cnt_next   = cnt_reg - CNT_W'(1);
            last_next  = (cnt_reg == CNT_W'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_byte  = byte_reg;
    assign last_byte = last_reg;

endmodule

### rtl/cbor_item_head_encoder.sv
// The initial byte is presented in the cycle after a request is accepted.
// Throughput: one byte per cycle while out_ready is high; a request holds the
//   block for its initial byte and N argument bytes (N = 0, 1, 2, 4 or 8), and
//   in_ready returns the cycle after the last byte is taken.
// Request kind 7 is dropped with no output. Reset (rst_n low, asynchronous)
//   clears the sequencer; no byte is pending after reset.
module cbor_item_head_encoder
    import cbor_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [2:0]   req_type,
    input  logic [63:0]  value,
    input  logic signed [31:0] int_value,
    input  logic         flag,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_byte,
    output logic         last_byte
);

    logic [63:0]       arg;
    logic [7:0]        major;
    logic [4:0]        info;
    logic [CNT_W-1:0]  nfollow;
    logic [63:0]       aligned;
    logic              busy;
    cbor_load_t        ld;

    // Argument and major type per request kind
    always_comb
    begin
        arg   = value;
        major = MT_UINT;
        case (req_type)
            REQ_INT:
            begin
                if (int_value[31])
                begin
                    arg   = {32'h0, ~int_value};
                    major = MT_NEGINT;
                end
                else
                begin
                    arg   = {32'h0, int_value};
                    major = MT_UINT;
                end
            end
            REQ_ARRAY: major = MT_ARRAY;
            REQ_MAP:   major = MT_MAP;
            REQ_TEXT:  major = MT_TEXT;
            REQ_BYTES: major = MT_BYTES;
            default:   major = MT_UINT;
        endcase
    end

    // Shortest head form
    always_comb
    begin
        if (arg < 64'd24)
        begin
            info    = arg[4:0];
            nfollow = CNT_W'(0);
        end
        else if (arg[63:8] == '0)
        begin
            info    = AI_ONE;
            nfollow = CNT_W'(1);
        end
        else if (arg[63:16] == '0)
        begin
            info    = AI_TWO;
            nfollow = CNT_W'(2);
        end
        else if (arg[63:32] == '0)
        begin
            info    = AI_FOUR;
            nfollow = CNT_W'(4);
        end
        else
        begin
            info    = AI_EIGHT;
            nfollow = CNT_W'(8);
        end
    end

    // Left-justify the argument bytes for the serializer
    always_comb
    begin
        case (nfollow)
            CNT_W'(1): aligned = {arg[7:0],  56'h0};
            CNT_W'(2): aligned = {arg[15:0], 48'h0};
            CNT_W'(4): aligned = {arg[31:0], 32'h0};
            default:   aligned = arg;
        endcase
    end

    // Load request to the serializer
    always_comb
    begin
        ld.load    = in_valid && in_ready && (req_type != REQ_RSVD);
        ld.head    = major | {3'b000, info};
        ld.nfollow = nfollow;
        ld.args    = aligned;
        unique case (req_type)
            REQ_BOOL:
            begin
                ld.head    = flag ? SV_TRUE : SV_FALSE;
                ld.nfollow = CNT_W'(0);
            end
            REQ_DOUBLE:
            begin
                ld.head    = SV_DOUBLE;
                ld.nfollow = CNT_W'(8);
                ld.args    = value;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready = !busy;

    cbor_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld        (ld),
        .busy      (busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

### tb/cbor_item_head_encoder_test.sv
module cbor_item_head_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cbor_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } head_byte_t;

    // Scoreboard: turns each accepted request into the byte run it should produce
    class head_scoreboard;
        head_byte_t head_bytes_q[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function void add_byte(logic [7:0] data, logic last);
            head_byte_t hb;
            hb.data = data;
            hb.last = last;
            head_bytes_q.push_back(hb);
        endfunction

        // Shortest-form head: info in the initial byte, then big-endian argument
        function void add_head(logic [7:0] major, logic [63:0] arg);
            logic [4:0] info;
            int nfollow;
            int i;
            if (arg < 64'd24)
            begin
                info = arg[4:0];
                nfollow = 0;
            end
            else if (arg <= 64'hFF)
            begin
                info = AI_ONE;
                nfollow = 1;
            end
            else if (arg <= 64'hFFFF)
            begin
                info = AI_TWO;
                nfollow = 2;
            end
            else if (arg <= 64'hFFFF_FFFF)
            begin
                info = AI_FOUR;
                nfollow = 4;
            end
            else
            begin
                info = AI_EIGHT;
                nfollow = 8;
            end
            add_byte(major | {3'b000, info}, nfollow == 0);
            for (i = nfollow - 1; i >= 0; i--)
                add_byte(arg[8*i +: 8], i == 0);
        endfunction

        function void note_request(logic [2:0] kind, logic [63:0] val,
                                   logic [31:0] ival, logic bflag);
            int i;
            case (kind)
                REQ_INT:
                begin
                    // negative: argument is the 32-bit complement
                    if (ival[31])
                        add_head(MT_NEGINT, {32'h0, ~ival});
                    else
                        add_head(MT_UINT, {32'h0, ival});
                end
                REQ_ARRAY:  add_head(MT_ARRAY, val);
                REQ_MAP:    add_head(MT_MAP, val);
                REQ_BOOL:   add_byte(bflag ? SV_TRUE : SV_FALSE, 1'b1);
                REQ_TEXT:   add_head(MT_TEXT, val);
                REQ_BYTES:  add_head(MT_BYTES, val);
                REQ_DOUBLE:
                begin
                    add_byte(SV_DOUBLE, 1'b0);
                    for (i = 7; i >= 0; i--)
                        add_byte(val[8*i +: 8], i == 0);
                end
                default: ;  // reserved kind: dropped
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH %s", $time, what);
        endtask

        task check_byte(logic [7:0] data, logic last);
            head_byte_t hb;
            if (head_bytes_q.size() == 0)
            begin
                report($sformatf("byte %02h last %0b with nothing pending", data, last));
            end
            else
            begin
                hb = head_bytes_q.pop_front();
                if (data !== hb.data)
                    report($sformatf("out_byte %02h, predicted %02h", data, hb.data));
                if (last !== hb.last)
                    report($sformatf("last_byte %0b, predicted %0b (byte %02h)",
                                     last, hb.last, hb.data));
            end
        endtask

        function int pending();
            return head_bytes_q.size();
        endfunction

        task check_drained();
            if (head_bytes_q.size() != 0)
                report($sformatf("%0d predicted bytes never arrived", head_bytes_q.size()));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    logic [2:0]   req_type;
    logic [63:0]  value;
    logic signed [31:0] int_value;
    logic         flag;
    logic         out_valid;
    logic         out_ready;
    logic [7:0]   out_byte;
    logic         last_byte;

    head_scoreboard sb;
    int src_idle_pct;
    int sink_idle_pct;
    int hold_cycles;
    int quiet_cycles;

    cbor_item_head_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .value     (value),
        .int_value (int_value),
        .flag      (flag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off while hold_cycles runs down
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(req_type, value, int_value, flag);
            if (out_valid && out_ready)
                sb.check_byte(out_byte, last_byte);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] timeout: no handshake for %0d cycles", $time, quiet_cycles);
                $display("cbor_item_head_encoder_test: errors");
                $finish;
            end
        end
    end

    // Offer one request, with an optional random gap first; returns at a falling edge
    task send_request(logic [2:0] kind, logic [63:0] val, logic [31:0] ival, logic bflag);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        value     <= val;
        int_value <= ival;
        flag      <= bflag;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Argument spread over every head size
    function logic [63:0] rand_arg();
        logic [63:0] r;
        case ($urandom_range(0, 5))
            0:       r = 64'($urandom_range(0, 23));
            1:       r = 64'($urandom_range(24, 255));
            2:       r = 64'($urandom_range(256, 65535));
            3:       r = {32'h0, 32'($urandom_range(32'h1_0000, 32'hFFFF_FFFF))};
            4:       r = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
            default: r = {32'($urandom), 32'($urandom)};
        endcase
        return r;
    endfunction

    function logic [31:0] rand_int();
        logic [31:0] r;
        r = 32'($urandom) >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1)
            r = ~r;
        return r;
    endfunction

    task run_phase(int src_pct, int snk_pct, int n_items, bit with_hold);
        int sent;
        bit held;
        logic [2:0] kind;
        sent = 0;
        held = 1'b0;
        src_idle_pct = src_pct;
        sink_idle_pct = snk_pct;
        while (sent < n_items)
        begin
            // long receiver hold-off halfway through, sender keeps offering
            if (with_hold && !held && sent >= n_items / 2)
            begin
                hold_cycles <= HOLD_OFF_CYCLES;
                held = 1'b1;
            end
            kind = 3'($urandom_range(0, 7));
            if (kind == REQ_RSVD && $urandom_range(0, 3) != 0)
                kind = 3'($urandom_range(0, 6));
            send_request(kind, rand_arg(), rand_int(), 1'($urandom_range(0, 1)));
            if (kind != REQ_RSVD)
                sent++;
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_INT;
        value = 64'h0;
        int_value = 32'sh0;
        flag = 1'b0;
        out_ready = 1'b0;
        hold_cycles = 0;
        quiet_cycles = 0;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: head size boundaries, sign extremes, every kind
        src_idle_pct = 20;
        sink_idle_pct = 30;
        send_request(REQ_INT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b1);
        send_request(REQ_INT, 64'h0, 32'd23, 1'b0);
        send_request(REQ_INT, 64'h0, 32'd24, 1'b0);
        send_request(REQ_INT, 64'h0, 32'd255, 1'b0);
        send_request(REQ_INT, 64'h0, 32'd256, 1'b0);
        send_request(REQ_INT, 64'h0, 32'd65535, 1'b0);
        send_request(REQ_INT, 64'h0, 32'd65536, 1'b0);
        send_request(REQ_INT, 64'h0, 32'h7FFF_FFFF, 1'b0);
        send_request(REQ_INT, 64'h0, 32'hFFFF_FFFF, 1'b0);     // -1
        send_request(REQ_INT, 64'h0, 32'hFFFF_FFE8, 1'b0);     // -24
        send_request(REQ_INT, 64'h0, 32'hFFFF_FFE7, 1'b0);     // -25
        send_request(REQ_INT, 64'h0, 32'hFFFE_FFFF, 1'b0);     // -65537
        send_request(REQ_INT, 64'h0, 32'h8000_0000, 1'b0);     // most negative
        send_request(REQ_ARRAY, 64'h0, 32'hFFFF_FFFF, 1'b1);
        send_request(REQ_ARRAY, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
        send_request(REQ_MAP, 64'd23, 32'h0, 1'b0);
        send_request(REQ_MAP, 64'd24, 32'h0, 1'b0);
        send_request(REQ_BOOL, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_request(REQ_BOOL, 64'h0, 32'h0, 1'b1);
        send_request(REQ_TEXT, 64'h1_0000, 32'h0, 1'b0);
        send_request(REQ_BYTES, 64'hFFFF_FFFF, 32'h0, 1'b0);
        send_request(REQ_BYTES, 64'h1_0000_0000, 32'h0, 1'b0);
        send_request(REQ_DOUBLE, 64'h0123_4567_89AB_CDEF, 32'h0, 1'b0);
        send_request(REQ_RSVD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(REQ_DOUBLE, 64'hFFF0_0000_0000_0001, 32'hFFFF_FFFF, 1'b1);

        // Random requests under three stall patterns
        run_phase(28, 61, 157, 1'b1);
        run_phase(61, 28, 157, 1'b0);
        run_phase(0, 0, 156, 1'b1);
        in_valid <= 1'b0;

        // Drain; the watchdog bounds this wait
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_drained();

        if (sb.errors == 0)
            $display("cbor_item_head_encoder_test: clean");
        else
            $display("cbor_item_head_encoder_test: errors");
        $finish;
    end

endmodule
